// ===== hw/rtl/utf8tv_pkg.sv =====
// Shared types and constants for the UTF-8 truncate and validate block.
`timescale 1ns / 1ps
`default_nettype none

package utf8tv_pkg;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 13;
  localparam int CFG_IDX_W = 2;

  // Largest string length the limits may ask for; larger limits are capped here.
  localparam logic [COUNT_W-1:0] LIMIT_CAP = 13'd4096;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

  // Result queue depth, including bytes of a character still being collected.
  localparam int QDEPTH = 16;
  localparam int QADDR_W = $clog2(QDEPTH);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd1;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               is_status;
    logic               well_formed;
    logic [COUNT_W-1:0] byte_count;
    logic [COUNT_W-1:0] char_count;
    logic               last_of_run;
  } result_t;

  // Queue command from the scanner, issued once per processed byte.
  typedef struct packed {
    logic    push;    // write entry at the tail
    logic    drop;    // discard uncommitted entries before the push
    logic    commit;  // make every entry up to the new tail visible
    result_t entry;
  } qcmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8tv_scan.sv =====
// Input register, configuration registers and the per-byte UTF-8 scanner.
`timescale 1ns / 1ps
`default_nettype none

module utf8tv_scan
  import utf8tv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [BYTE_W-1:0]    in_byte,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COUNT_W-1:0]   cfg_data,
  input  wire logic                 q_room,
  output qcmd_t                     q_cmd
);

  typedef enum logic [1:0] {
    MODE_LEAD = 2'd0,
    MODE_CONT = 2'd1,
    MODE_STOP = 2'd2
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic               vld_r, vld_nxt;
  logic [2:0]         held_r, held_nxt;
  logic [2:0]         need_r, need_nxt;
  logic [COUNT_W-1:0] kbytes_r, kbytes_nxt;
  logic [COUNT_W-1:0] kchars_r, kchars_nxt;
  logic               valid_r, valid_nxt;
  logic [COUNT_W-1:0] max_chars_r, max_chars_nxt;
  logic [COUNT_W-1:0] max_bytes_r, max_bytes_nxt;

  logic               go;
  logic [2:0]         extra;
  logic               at_limit;
  logic [COUNT_W:0]   bsum;

  // Continuation bytes announced by a lead byte; 6 marks an invalid lead.
  function automatic logic [2:0] lead_extra(input logic [BYTE_W-1:0] b);
    logic [2:0] e;
    if (b[7] == 1'b0)               e = 3'd0;
    else if (b[7:5] == 3'b110)      e = 3'd1;
    else if (b[7:4] == 4'b1110)     e = 3'd2;
    else if (b[7:3] == 5'b11110)    e = 3'd3;
    else if (b[7:2] == 6'b111110)   e = 3'd4;
    else if (b[7:1] == 7'b1111110)  e = 3'd5;
    else                            e = 3'd6;
    return e;
  endfunction

  function automatic logic [COUNT_W-1:0] cap(input logic [COUNT_W-1:0] v);
    return (v > LIMIT_CAP) ? LIMIT_CAP : v;
  endfunction

  assign go        = vld_r & q_room;
  assign in_tready = ~vld_r | q_room;

  assign extra    = lead_extra(byte_r);
  assign at_limit = (kbytes_r >= cap(max_bytes_r)) || (kchars_r >= cap(max_chars_r));

  // Byte count once the current byte finishes a character.
  always_comb begin
    if (mode_r == MODE_CONT) begin
      bsum = {1'b0, kbytes_r} + (COUNT_W+1)'(held_r) + (COUNT_W+1)'(1);
    end else begin
      bsum = {1'b0, kbytes_r} + (COUNT_W+1)'(1);
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    byte_nxt      = byte_r;
    vld_nxt       = vld_r;
    held_nxt      = held_r;
    need_nxt      = need_r;
    kbytes_nxt    = kbytes_r;
    kchars_nxt    = kchars_r;
    valid_nxt     = valid_r;
    max_chars_nxt = max_chars_r;
    max_bytes_nxt = max_bytes_r;
    q_cmd         = '0;
    q_cmd.entry.out_byte = byte_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_CHARS: max_chars_nxt = cfg_data;
        CFG_MAX_BYTES: max_bytes_nxt = cfg_data;
        default: ;
      endcase
    end

    if (in_tvalid && in_tready) begin
      byte_nxt = in_byte;
      vld_nxt  = 1'b1;
    end else if (go) begin
      vld_nxt  = 1'b0;
    end

    if (go) begin
      if (byte_r == '0) begin
        // Terminator: drop any partial character and report the counts.
        q_cmd.push              = 1'b1;
        q_cmd.drop              = 1'b1;
        q_cmd.commit            = 1'b1;
        q_cmd.entry.out_byte    = '0;
        q_cmd.entry.is_status   = 1'b1;
        q_cmd.entry.well_formed = valid_r & (mode_r != MODE_CONT);
        q_cmd.entry.byte_count  = kbytes_r;
        q_cmd.entry.char_count  = kchars_r;
        q_cmd.entry.last_of_run = 1'b1;
        mode_nxt   = MODE_LEAD;
        held_nxt   = '0;
        need_nxt   = '0;
        kbytes_nxt = '0;
        kchars_nxt = '0;
        valid_nxt  = 1'b1;
      end else begin
        case (mode_r)
          MODE_LEAD: begin
            if (at_limit) begin
              mode_nxt = MODE_STOP;
            end else if (extra == 3'd0) begin
              q_cmd.push              = 1'b1;
              q_cmd.commit            = 1'b1;
              q_cmd.entry.last_of_run = 1'b1;
              kbytes_nxt = bsum[COUNT_W] ? COUNT_MAX : bsum[COUNT_W-1:0];
              kchars_nxt = kchars_r + COUNT_W'(1);
            end else if (extra == 3'd6) begin
              valid_nxt = 1'b0;
              mode_nxt  = MODE_STOP;
            end else begin
              q_cmd.push = 1'b1;
              held_nxt   = 3'd1;
              need_nxt   = extra;
              mode_nxt   = MODE_CONT;
            end
          end
          MODE_CONT: begin
            if (byte_r[7:6] != 2'b10) begin
              // Bad continuation: the held character is thrown away.
              q_cmd.drop = 1'b1;
              valid_nxt  = 1'b0;
              mode_nxt   = MODE_STOP;
            end else begin
              q_cmd.push = 1'b1;
              held_nxt   = held_r + 3'd1;
              need_nxt   = need_r - 3'd1;
              if (need_r == 3'd1) begin
                q_cmd.commit            = 1'b1;
                q_cmd.entry.last_of_run = 1'b1;
                kbytes_nxt = bsum[COUNT_W] ? COUNT_MAX : bsum[COUNT_W-1:0];
                kchars_nxt = kchars_r + COUNT_W'(1);
                held_nxt   = '0;
                mode_nxt   = MODE_LEAD;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    if (!rst_n) begin
      mode_r      <= MODE_LEAD;
      vld_r       <= 1'b0;
      held_r      <= '0;
      need_r      <= '0;
      kbytes_r    <= '0;
      kchars_r    <= '0;
      valid_r     <= 1'b1;
      max_chars_r <= LIMIT_CAP;
      max_bytes_r <= LIMIT_CAP;
    end else begin
      mode_r      <= mode_nxt;
      vld_r       <= vld_nxt;
      held_r      <= held_nxt;
      need_r      <= need_nxt;
      kbytes_r    <= kbytes_nxt;
      kchars_r    <= kchars_nxt;
      valid_r     <= valid_nxt;
      max_chars_r <= max_chars_nxt;
      max_bytes_r <= max_bytes_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8tv_queue.sv =====
// Result queue with a commit pointer, followed by the output register.
`timescale 1ns / 1ps
`default_nettype none

module utf8tv_queue
  import utf8tv_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  qcmd_t      q_cmd,
  output logic       q_room,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output result_t    out_item
);

  result_t            mem [QDEPTH];
  logic [QADDR_W:0]   head_r, head_nxt;
  logic [QADDR_W:0]   tail_r, tail_nxt;
  logic [QADDR_W:0]   cmt_r, cmt_nxt;
  logic [QADDR_W:0]   base;
  logic [QADDR_W:0]   used;
  logic               avail;
  logic               load;
  logic               ovld_r, ovld_nxt;
  result_t            item_r;

  assign used   = tail_r - head_r;
  assign q_room = (used < (QADDR_W+1)'(QDEPTH));
  assign avail  = (cmt_r != head_r);
  assign load   = avail & (~ovld_r | out_tready);
  assign base   = q_cmd.drop ? cmt_r : tail_r;

  always_comb begin
    tail_nxt = base + (QADDR_W+1)'(q_cmd.push);
    cmt_nxt  = q_cmd.commit ? tail_nxt : cmt_r;
    head_nxt = head_r + (QADDR_W+1)'(load);
    if (load) begin
      ovld_nxt = 1'b1;
    end else if (out_tready) begin
      ovld_nxt = 1'b0;
    end else begin
      ovld_nxt = ovld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_cmd.push) begin
      mem[base[QADDR_W-1:0]] <= q_cmd.entry;
    end
    if (load) begin
      item_r <= mem[head_r[QADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cmt_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cmt_r  <= cmt_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_item   = item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_truncate_validate_top.sv =====
// Top level of the streaming UTF-8 truncate and validate block.
//
//   Channel  Direction  Handshake               Payload
//   in_      slave      in_tvalid / in_tready   in_tdata: data_byte
//   out_     master     out_tvalid / out_tready out_tdata, out_tuser, out_tlast
//   cfg_     slave      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte transfer is taken per clock. A byte waits in the input register,
// and its result reaches the output register through a 16-entry queue.
// Bytes of a multibyte character wait there uncommitted until the last
// continuation byte; a bad byte or the terminator rewinds the tail over them.
// The input stalls only while the queue is full.
// rst_n is synchronous and sets both limits to 4096; configuration is always ready.
`timescale 1ns / 1ps
`default_nettype none

module utf8_truncate_validate_top
  import utf8tv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input bytes. in_tdata: [7:0] data_byte.
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,
  // Results. out_tdata: [7:0] out_byte, [8] well_formed, [21:9] byte_count,
  // [34:22] char_count, [39:35] zero. out_tuser: [0] is_status.
  // out_tlast: last_of_run.
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [39:0]               out_tdata,
  output logic                      out_tuser,
  output logic                      out_tlast,
  // Configuration writes: index 0 is max_chars, index 1 is max_bytes.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COUNT_W-1:0]   cfg_data
);

  qcmd_t   q_cmd;
  logic    q_room;
  result_t out_item;

  assign cfg_ready = 1'b1;

  utf8tv_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_room    (q_room),
    .q_cmd     (q_cmd)
  );

  utf8tv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_cmd      (q_cmd),
    .q_room     (q_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_item   (out_item)
  );

  // Byte items carry zero status fields, so the packing needs no muxing.
  assign out_tdata = {5'd0, out_item.char_count, out_item.byte_count,
                      out_item.well_formed, out_item.out_byte};
  assign out_tuser = out_item.is_status;
  assign out_tlast = out_item.last_of_run;

endmodule

`default_nettype wire

// ===== verif/utf8tv_checker.sv =====
// Result checker for the UTF-8 truncate and validate block.
`timescale 1ns / 1ps

module utf8tv_checker
  import utf8tv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  input  wire logic                 in_tready,
  input  wire logic [7:0]           in_tdata,
  input  wire logic                 out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic [39:0]          out_tdata,
  input  wire logic                 out_tuser,
  input  wire logic                 out_tlast,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COUNT_W-1:0]   cfg_data,
  output int unsigned               fail_count,
  output int unsigned               results_pending
);

  typedef enum logic [1:0] {
    SCAN_LEAD = 2'd0,
    SCAN_CONT = 2'd1,
    SCAN_STOP = 2'd2
  } scan_t;

  localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

  scan_t              scan_mode;
  logic [BYTE_W-1:0]  held_bytes [6];
  int unsigned        held_n;
  int unsigned        conts_left;
  logic [COUNT_W-1:0] kept_bytes;
  logic [COUNT_W-1:0] kept_chars;
  logic               still_clean;
  logic [COUNT_W-1:0] lim_chars;
  logic [COUNT_W-1:0] lim_bytes;
  result_t            result_due_q [$];
  int unsigned        mismatches;

  initial begin
    mismatches = 0;
  end

  // Continuation bytes announced by a lead byte; 6 flags a bad lead.
  function automatic int unsigned cont_count(input logic [BYTE_W-1:0] b);
    casez (b)
      8'b0???????: return 0;
      8'b110?????: return 1;
      8'b1110????: return 2;
      8'b11110???: return 3;
      8'b111110??: return 4;
      8'b1111110?: return 5;
      default:     return 6;
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] capped(input logic [COUNT_W-1:0] v);
    return (v > LIMIT_CAP) ? LIMIT_CAP : v;
  endfunction

  task automatic clear_string();
    scan_mode   = SCAN_LEAD;
    held_n      = 0;
    conts_left  = 0;
    kept_bytes  = '0;
    kept_chars  = '0;
    still_clean = 1'b1;
  endtask

  task automatic expect_byte(input logic [BYTE_W-1:0] b, input logic last);
    result_t r;
    r             = '0;
    r.out_byte    = b;
    r.last_of_run = last;
    result_due_q.push_back(r);
  endtask

  // Counts one finished character of n bytes; the byte count saturates.
  task automatic count_char(input int unsigned n);
    int unsigned sum;
    sum        = kept_bytes + n;
    kept_bytes = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
    kept_chars = kept_chars + 1'b1;
  endtask

  task automatic predict_byte(input logic [BYTE_W-1:0] b);
    result_t     r;
    int unsigned extra;
    int unsigned k;
    if (b == TERMINATOR) begin
      // A terminator in the middle of a character is a bad continuation.
      if (scan_mode == SCAN_CONT) still_clean = 1'b0;
      r             = '0;
      r.is_status   = 1'b1;
      r.well_formed = still_clean;
      r.byte_count  = kept_bytes;
      r.char_count  = kept_chars;
      r.last_of_run = 1'b1;
      result_due_q.push_back(r);
      clear_string();
    end else begin
      case (scan_mode)
        SCAN_LEAD: begin
          extra = cont_count(b);
          if (kept_bytes >= capped(lim_bytes) || kept_chars >= capped(lim_chars)) begin
            // Limit hit: stop quietly, even on a bad byte.
            scan_mode = SCAN_STOP;
          end else if (extra == 0) begin
            expect_byte(b, 1'b1);
            count_char(1);
          end else if (extra > 5) begin
            still_clean = 1'b0;
            scan_mode   = SCAN_STOP;
          end else begin
            held_bytes[0] = b;
            held_n        = 1;
            conts_left    = extra;
            scan_mode     = SCAN_CONT;
          end
        end
        SCAN_CONT: begin
          if (b[7:6] != 2'b10 || held_n >= 6) begin
            still_clean = 1'b0;
            scan_mode   = SCAN_STOP;
          end else begin
            held_bytes[held_n] = b;
            held_n++;
            if (conts_left > 0) conts_left--;
            if (conts_left == 0) begin
              for (k = 0; k < held_n; k++) expect_byte(held_bytes[k], k == held_n - 1);
              count_char(held_n);
              held_n    = 0;
              scan_mode = SCAN_LEAD;
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      lim_chars = LIMIT_CAP;
      lim_bytes = LIMIT_CAP;
      clear_string();
      result_due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_CHARS: lim_chars = cfg_data;
          CFG_MAX_BYTES: lim_bytes = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (result_due_q.size() == 0) begin
          $error("result transfer with none expected: tdata %h tuser %b tlast %b",
                 out_tdata, out_tuser, out_tlast);
          mismatches++;
        end else begin
          want = result_due_q.pop_front();
          check_field("out_byte", want.out_byte, out_tdata[7:0]);
          check_field("is_status", want.is_status, out_tuser);
          check_field("well_formed", want.well_formed, out_tdata[8]);
          check_field("byte_count", want.byte_count, out_tdata[21:9]);
          check_field("char_count", want.char_count, out_tdata[34:22]);
          check_field("last_of_run", want.last_of_run, out_tlast);
        end
      end
    end
    fail_count      <= mismatches;
    results_pending <= result_due_q.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the UTF-8 truncate and validate block: stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import utf8tv_pkg::*;

  // Cycles to let a byte that causes no result clear the input register and
  // queue before the limits are touched.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned NUM_PHASES    = 8;

  // Indexes past the register list; the block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [39:0]          out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COUNT_W-1:0]   cfg_data;

  int unsigned fail_count;
  int unsigned results_pending;

  // Random idling on both sides is switched off for two long stretches.
  bit          gaps_on;
  // Cycles the receiver still has to hold off; set by the stimulus process.
  int unsigned hold_left;
  int unsigned sent_bytes;

  utf8_truncate_validate_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  utf8tv_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("utf8_truncate_validate_top verification failed");
    $finish;
  end

  // Receiver: changes out_tready on the falling edge only. A requested hold-off
  // wins over the random stalls, drawn with odds of 12 in 100 while gaps_on is set.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (gaps_on && $urandom_range(99) < 12) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offers one byte and returns at the rising edge where the transfer happens.
  // Random gaps come before the offer, never while a byte is waiting.
  task automatic push_byte(input logic [7:0] b);
    if (gaps_on) begin
      while ($urandom_range(99) < 12) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sent_bytes++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops sending and waits until every predicted result has been seen, then
  // lets any byte that produces nothing work its way through the block.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_limits(input logic [COUNT_W-1:0] chars, input logic [COUNT_W-1:0] bytes);
    write_reg(CFG_MAX_CHARS, chars);
    write_reg(CFG_MAX_BYTES, bytes);
  endtask

  // Sends the first upto bytes of a well-formed character of n bytes with
  // random payload bits. upto < n leaves the character unfinished.
  task automatic send_char(input int unsigned n, input int unsigned upto);
    logic [7:0]  lead;
    int unsigned k;
    case (n)
      1:       lead = 8'($urandom_range(1, 127));
      2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
      3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
      4:       lead = 8'hF0 | 8'($urandom_range(0, 7));
      5:       lead = 8'hF8 | 8'($urandom_range(0, 3));
      default: lead = 8'hFC | 8'($urandom_range(0, 1));
    endcase
    push_byte(lead);
    for (k = 1; k < upto; k++) push_byte(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  // A random string of up to nchars characters followed by the terminator.
  // Most characters are well formed; the rest are bad leads, characters broken
  // by a byte that is not a continuation, characters cut off by the terminator,
  // and plain noise.
  task automatic send_text(input int unsigned nchars);
    int unsigned pick;
    int unsigned len;
    int unsigned i;
    bit          cut;
    logic [7:0]  b;
    cut = 1'b0;
    for (i = 0; i < nchars && !cut; i++) begin
      pick = $urandom_range(99);
      len  = $urandom_range(2, 6);
      if (pick < 92) begin
        if ($urandom_range(1) == 1) len = 1;
        send_char(len, len);
      end else if (pick < 94) begin
        case ($urandom_range(2))
          0:       b = 8'h80 | 8'($urandom_range(0, 63));
          1:       b = 8'hFE;
          default: b = 8'hFF;
        endcase
        push_byte(b);
      end else if (pick < 96) begin
        send_char(len, $urandom_range(1, len - 1));
        if ($urandom_range(1) == 1) b = 8'($urandom_range(1, 127));
        else b = 8'($urandom_range(8'hC0, 8'hFF));
        push_byte(b);
      end else if (pick < 98) begin
        send_char(len, $urandom_range(1, len - 1));
        cut = 1'b1;
      end else begin
        push_byte(8'($urandom_range(1, 255)));
      end
    end
    push_byte(TERMINATOR);
  endtask

  initial begin
    int unsigned phase;
    int unsigned budget;
    int unsigned i;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_MAX_CHARS;
    cfg_data   = '0;
    gaps_on    = 1'b1;
    hold_left  = 0;
    sent_bytes = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with both limits at their reset value. First the top
    // ASCII byte and one character of every length from two to six bytes.
    push_byte(8'h7F);
    push_byte(8'hC2); push_byte(8'h80);
    push_byte(8'hE0); push_byte(8'h80); push_byte(8'h80);
    push_byte(8'hF4); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF);
    push_byte(8'hF8); push_byte(8'h80); push_byte(8'h80); push_byte(8'h80);
    push_byte(8'h80);
    push_byte(8'hFD); push_byte(8'hBF); push_byte(8'hBF); push_byte(8'hBF);
    push_byte(8'hBF); push_byte(8'hBF);
    push_byte(TERMINATOR);
    // A stray continuation byte and the two bytes that never lead.
    push_byte(8'h80); push_byte(TERMINATOR);
    push_byte(8'hFE); push_byte(TERMINATOR);
    push_byte(8'hFF); push_byte(TERMINATOR);
    // The terminator arriving inside a character.
    push_byte(8'hDF); push_byte(TERMINATOR);
    // A three-byte character broken by a lead byte in continuation position.
    push_byte(8'hEF); push_byte(8'hBF); push_byte(8'hC3); push_byte(TERMINATOR);

    // Random part in phases. Each phase starts from an idle block, so the
    // sender also pauses here until every expected result has come back.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      gaps_on = 1'b1;
      budget  = 12;
      case (phase)
        0: set_limits(COUNT_MAX, LIMIT_CAP);
        1: begin
          // No characters allowed: a bad byte after the limit stops quietly
          // and leaves the string marked well formed.
          set_limits('0, LIMIT_CAP);
          push_byte(8'hFF);
          push_byte(TERMINATOR);
          budget = 10;
        end
        2: begin
          set_limits(COUNT_MAX, '0);
          budget = 10;
        end
        3: begin
          // A long stretch with no idling on either side.
          set_limits(13'd3, COUNT_MAX);
          gaps_on = 1'b0;
          budget  = 30;
        end
        4: begin
          // The four-byte character starts below the byte limit and is kept
          // whole; the next character finds the limit reached.
          set_limits(LIMIT_CAP, 13'd5);
          push_byte(8'h41);
          push_byte(8'hF0); push_byte(8'h80); push_byte(8'h80); push_byte(8'h80);
          push_byte(8'h41);
          push_byte(TERMINATOR);
        end
        5: begin
          // Writes past the register list, then a long receiver hold-off while
          // the sender keeps offering ASCII, so the queue fills and the input
          // stalls.
          set_limits(LIMIT_CAP, LIMIT_CAP);
          write_reg(CFG_SPARE_A, '0);
          write_reg(CFG_SPARE_B, COUNT_MAX);
          gaps_on   = 1'b0;
          hold_left = 120;
          for (i = 0; i < 40; i++) send_char(1, 1);
          push_byte(TERMINATOR);
          gaps_on = 1'b1;
          budget  = 0;
        end
        default: set_limits(COUNT_W'($urandom_range(1, 12)), COUNT_W'($urandom_range(1, 24)));
      endcase
      budget = sent_bytes + budget;
      while (sent_bytes < budget) send_text($urandom_range(0, 10));
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("utf8_truncate_validate_top verification clean");
    end else begin
      $display("utf8_truncate_validate_top verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/utf8tv_pkg.sv
hw/rtl/utf8tv_scan.sv
hw/rtl/utf8tv_queue.sv
hw/rtl/utf8_truncate_validate_top.sv
verif/utf8tv_checker.sv
verif/tb.sv
